// ----- hdl/key_to_terminal_byte_encoder_assert.svh -----
// Assertion macros for the terminal byte encoder checks.
`ifndef KEY_TO_TERMINAL_BYTE_ENCODER_ASSERT_SVH
`define KEY_TO_TERMINAL_BYTE_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define KTE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kte check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define KTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kte check failed");

`endif

// ----- hdl/kte_pkg.sv -----
`default_nettype none

package kte_pkg;

   // Label codes for named keys
   localparam logic [7:0] K_ESC   = 8'h80;
   localparam logic [7:0] K_TAB   = 8'h81;
   localparam logic [7:0] K_BS    = 8'h82;
   localparam logic [7:0] K_ENTER = 8'h83;
   localparam logic [7:0] K_UP    = 8'h84;
   localparam logic [7:0] K_DOWN  = 8'h85;
   localparam logic [7:0] K_RIGHT = 8'h86;
   localparam logic [7:0] K_LEFT  = 8'h87;
   localparam logic [7:0] K_HOME  = 8'h88;
   localparam logic [7:0] K_END   = 8'h89;
   localparam logic [7:0] K_PGUP  = 8'h8A;
   localparam logic [7:0] K_PGDN  = 8'h8B;
   localparam logic [7:0] K_INS   = 8'h8C;
   localparam logic [7:0] K_DEL   = 8'h8D;
   localparam logic [7:0] K_CTRL  = 8'h8E;
   localparam logic [7:0] K_SHIFT = 8'h8F;
   localparam logic [7:0] K_SYM   = 8'h90;
   // Marks a position past the layer's key count
   localparam logic [7:0] K_NONE  = 8'hFF;

   // Layer codes; the fourth code reads and toggles like base
   localparam logic [1:0] LAYER_BASE  = 2'd0;
   localparam logic [1:0] LAYER_SHIFT = 2'd1;
   localparam logic [1:0] LAYER_SYM   = 2'd2;

   // Terminal byte constants
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_CSI   = 8'h5B;
   localparam logic [7:0] CH_SS3   = 8'h4F;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CTRL_MASK = 8'h1F;

   localparam int MAP_DEPTH = 64;

   // Base layer, row by row
   localparam logic [7:0] BASE_MAP [0:MAP_DEPTH-1] = '{
      8'h80, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h82,
      8'h81, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
      8'h8E, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h83,
      8'h8F, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h27,
      8'h90, 8'h2D, 8'h2F, 8'h20, 8'h87, 8'h84, 8'h85, 8'h86,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   // One-shot shift layer
   localparam logic [7:0] SHIFT_MAP [0:MAP_DEPTH-1] = '{
      8'h80, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h82,
      8'h81, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
      8'h8E, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h83,
      8'h8F, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h22,
      8'h90, 8'h5F, 8'h3F, 8'h20, 8'h87, 8'h84, 8'h85, 8'h86,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   // Latched symbol layer
   localparam logic [7:0] SYM_MAP [0:MAP_DEPTH-1] = '{
      8'h80, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h82,
      8'h81, 8'h7E, 8'h60, 8'h7C, 8'h5C, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3C, 8'h3E,
      8'h8E, 8'h3B, 8'h3A, 8'h22, 8'h3D, 8'h2B, 8'h5F, 8'h3F, 8'h83,
      8'h8F, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D,
      8'h90, 8'h2D, 8'h2F, 8'h20, 8'h87, 8'h84, 8'h85, 8'h86,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   // One encoded key: bytes in send order, index of the final byte
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } seq_type;

   // Queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Fold a printable character under an armed Ctrl
   function automatic logic [7:0] ctrl_fold(input logic [7:0] ch);
      logic [7:0] up;
      logic [7:0] res;
      up  = (ch >= 8'h61 && ch <= 8'h7A) ? ch - CH_SPACE : ch;
      res = ch;
      if (ch == CH_SPACE) begin
         res = 8'h00;
      end else if (up >= 8'h40 && up <= 8'h5F) begin
         res = up & CTRL_MASK;
      end
      return res;
   endfunction

   // Turn an emitting label into its terminal byte sequence
   function automatic seq_type encode_key(input logic [7:0] key, input logic ctrl,
                                          input logic app);
      seq_type    s;
      logic [7:0] cur;
      s   = '0;
      cur = app ? CH_SS3 : CH_CSI;
      s.bytes[0] = CH_ESC;
      if (key < 8'h80) begin
         s.bytes[0] = ctrl ? ctrl_fold(key) : key;
         s.last_idx = 2'd0;
      end else begin
         unique case (key)
            K_ESC:   s.last_idx = 2'd0;
            K_TAB:   begin s.bytes[0] = CH_TAB; s.last_idx = 2'd0; end
            K_BS:    begin s.bytes[0] = CH_DEL; s.last_idx = 2'd0; end
            K_ENTER: begin s.bytes[0] = CH_CR;  s.last_idx = 2'd0; end
            K_UP:    begin s.bytes[1] = cur; s.bytes[2] = 8'h41; s.last_idx = 2'd2; end
            K_DOWN:  begin s.bytes[1] = cur; s.bytes[2] = 8'h42; s.last_idx = 2'd2; end
            K_RIGHT: begin s.bytes[1] = cur; s.bytes[2] = 8'h43; s.last_idx = 2'd2; end
            K_LEFT:  begin s.bytes[1] = cur; s.bytes[2] = 8'h44; s.last_idx = 2'd2; end
            K_HOME:  begin s.bytes[1] = cur; s.bytes[2] = 8'h48; s.last_idx = 2'd2; end
            K_END:   begin s.bytes[1] = cur; s.bytes[2] = 8'h46; s.last_idx = 2'd2; end
            K_PGUP:  begin
               s.bytes[1] = CH_CSI; s.bytes[2] = 8'h35; s.bytes[3] = CH_TILDE;
               s.last_idx = 2'd3;
            end
            K_PGDN:  begin
               s.bytes[1] = CH_CSI; s.bytes[2] = 8'h36; s.bytes[3] = CH_TILDE;
               s.last_idx = 2'd3;
            end
            K_INS:   begin
               s.bytes[1] = CH_CSI; s.bytes[2] = 8'h32; s.bytes[3] = CH_TILDE;
               s.last_idx = 2'd3;
            end
            default: begin
               s.bytes[1] = CH_CSI; s.bytes[2] = 8'h33; s.bytes[3] = CH_TILDE;
               s.last_idx = 2'd3;
            end
         endcase
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/key_to_terminal_byte_encoder.sv -----
// Channel | Direction | Fields                         | Handshake
// req_    | in        | key_position, app_cursor_mode  | req_valid / req_ready
// rsp_    | out       | out_byte, last_byte            | rsp_valid / rsp_ready
//
// A key press is classified in the cycle it is taken; its bytes leave one per
// cycle while rsp_ready is high, 1 to 4 per key, from one output register.
// Modifier keys and positions past the layer's key count produce no bytes.
// req_ready drops only while the sequence queue (QUEUE_DEPTH keys) is full.
// Synchronous reset returns to the base layer with Ctrl unarmed and empties
// the queue and output register.
`default_nettype none

module key_to_terminal_byte_encoder import kte_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [5:0] req_key_position,
   input  wire logic       req_app_cursor_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_byte
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   seq_type          q_push_data, q_pop_data;

   // Classify keys and keep the layer and Ctrl state
   kte_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_key_position    (req_key_position),
      .req_app_cursor_mode (req_app_cursor_mode),
      .q_status            (q_status),
      .q_push              (q_push),
      .q_data              (q_push_data)
   );

   // Hold encoded sequences between the two sides
   kte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Send each sequence byte by byte
   kte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

// ----- hdl/kte_queue.sv -----
`default_nettype none

module kte_queue import kte_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire seq_type          push_data,
   input  wire logic             pop,
   output seq_type               pop_data,
   output queue_status_type      status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   seq_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full      = (count_ff == CNT_FULL);
   assign status.not_empty = (count_ff != '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && status.not_empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kte_front.sv -----
`default_nettype none

module kte_front import kte_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [5:0]       req_key_position,
   input  wire logic             req_app_cursor_mode,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output seq_type               q_data
);

   logic [1:0] layer_ff, layer_in;
   logic       ctrl_ff, ctrl_in;
   logic [7:0] label;
   logic       accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Look the label up in the active layer map
   always_comb begin
      unique case (layer_ff)
         LAYER_SYM:   label = SYM_MAP[req_key_position];
         LAYER_SHIFT: label = SHIFT_MAP[req_key_position];
         default:     label = BASE_MAP[req_key_position];
      endcase
   end

   assign q_data = encode_key(label, ctrl_ff, req_app_cursor_mode);

   // Classify the key: modifiers change state, other in-range keys go to the queue
   always_comb begin
      layer_in = layer_ff;
      ctrl_in  = ctrl_ff;
      q_push   = 1'b0;
      if (accept && label != K_NONE) begin
         priority if (label == K_CTRL) begin
            ctrl_in = ~ctrl_ff;
         end else if (label == K_SHIFT) begin
            layer_in = (layer_ff == LAYER_SHIFT) ? LAYER_BASE : LAYER_SHIFT;
         end else if (label == K_SYM) begin
            layer_in = (layer_ff == LAYER_SYM) ? LAYER_BASE : LAYER_SYM;
         end else begin
            q_push  = 1'b1;
            ctrl_in = 1'b0;
            if (layer_ff == LAYER_SHIFT) begin
               layer_in = LAYER_BASE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff <= LAYER_BASE;
         ctrl_ff  <= 1'b0;
      end else begin
         layer_ff <= layer_in;
         ctrl_ff  <= ctrl_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kte_back.sv -----
`default_nettype none

module kte_back import kte_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire seq_type          q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte
);

   logic            valid_ff, valid_in;
   logic [3:0][7:0] bytes_ff, bytes_in;
   logic [1:0]      left_ff, left_in;
   logic            sent_last;

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = bytes_ff[0];
   assign rsp_last_byte = (left_ff == 2'd0);
   assign sent_last     = valid_ff && rsp_ready && rsp_last_byte;
   assign q_pop         = q_status.not_empty && (!valid_ff || sent_last);

   // Shift out the current sequence, load the next one behind its last byte
   always_comb begin
      valid_in = valid_ff;
      bytes_in = bytes_ff;
      left_in  = left_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         bytes_in = q_data.bytes;
         left_in  = q_data.last_idx;
      end else if (sent_last) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         bytes_in = {8'h00, bytes_ff[3:1]};
         left_in  = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      left_ff  <= left_in;
   end

endmodule

`default_nettype wire

// ----- hdl/kte_checker.sv -----
`default_nettype none

`include "key_to_terminal_byte_encoder_assert.svh"

module kte_checker import kte_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [5:0] req_key_position,
   input wire logic       req_app_cursor_mode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_byte
);

   logic       req_stall;
   logic [6:0] req_payload;
   logic       rsp_stall;
   logic [8:0] rsp_payload;
   logic       mid_byte_ok;

   assign req_stall   = req_valid && !req_ready;
   assign req_payload = {req_key_position, req_app_cursor_mode};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_byte, rsp_last_byte};

   // Bytes that may sit inside an escape sequence
   assign mid_byte_ok = (rsp_out_byte == CH_ESC) || (rsp_out_byte == CH_CSI) ||
                        (rsp_out_byte == CH_SS3) || (rsp_out_byte == 8'h35) ||
                        (rsp_out_byte == 8'h36) || (rsp_out_byte == 8'h32) ||
                        (rsp_out_byte == 8'h33);

   // Nothing is offered straight after reset
   `KTE_ASSERT_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid)

   // A waiting key press holds
   `KTE_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_payload))

   // A stalled byte holds
   `KTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // A sequence keeps going without a gap once started
   `KTE_ASSERT_NEXT(a_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp_last_byte, rsp_valid)

   // Only escape-sequence bytes are followed by more bytes
   `KTE_ASSERT_NOW(a_mid_bytes, clock, reset, rsp_valid && !rsp_last_byte, mid_byte_ok)

endmodule

bind key_to_terminal_byte_encoder kte_checker u_kte_checker (.*);

`default_nettype wire

// ----- dv/key_to_terminal_byte_encoder_checker.sv -----
module key_to_terminal_byte_encoder_checker import kte_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [5:0] req_key_position,
   input  wire logic       req_app_cursor_mode,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_last_byte,
   output int              fail_count,
   output int              bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PLAIN_KEY_COUNT  = 53;
   localparam int SYMBOL_KEY_COUNT = 47;

   // Labels per layer, row by row
   localparam logic [7:0] PLAIN_KEYS [0:PLAIN_KEY_COUNT-1] = '{
      K_ESC, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, K_BS,
      K_TAB, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
      K_CTRL, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, K_ENTER,
      K_SHIFT, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h27,
      K_SYM, 8'h2D, 8'h2F, 8'h20, K_LEFT, K_UP, K_DOWN, K_RIGHT
   };
   localparam logic [7:0] SHIFTED_KEYS [0:PLAIN_KEY_COUNT-1] = '{
      K_ESC, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, K_BS,
      K_TAB, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
      K_CTRL, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, K_ENTER,
      K_SHIFT, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h22,
      K_SYM, 8'h5F, 8'h3F, 8'h20, K_LEFT, K_UP, K_DOWN, K_RIGHT
   };
   localparam logic [7:0] SYMBOL_KEYS [0:SYMBOL_KEY_COUNT-1] = '{
      K_ESC, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, K_BS,
      K_TAB, 8'h7E, 8'h60, 8'h7C, 8'h5C, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3C, 8'h3E,
      K_CTRL, 8'h3B, 8'h3A, 8'h22, 8'h3D, 8'h2B, 8'h5F, 8'h3F, K_ENTER,
      K_SHIFT, K_HOME, K_END, K_PGUP, K_PGDN, K_INS, K_DEL,
      K_SYM, 8'h2D, 8'h2F, 8'h20, K_LEFT, K_UP, K_DOWN, K_RIGHT
   };

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } term_byte_type;

   term_byte_type term_bytes_q [$];
   logic [1:0] layer_now;
   logic       ctrl_armed;

   initial fail_count = 0;
   initial bytes_pending = 0;

   // Look up a label; K_NONE past the layer's key count
   function automatic logic [7:0] label_at(input logic [1:0] layer, input logic [5:0] pos);
      logic [7:0] label;
      label = K_NONE;
      case (layer)
         LAYER_SYM: begin
            if (pos < SYMBOL_KEY_COUNT) label = SYMBOL_KEYS[pos];
         end
         LAYER_SHIFT: begin
            if (pos < PLAIN_KEY_COUNT) label = SHIFTED_KEYS[pos];
         end
         default: begin
            if (pos < PLAIN_KEY_COUNT) label = PLAIN_KEYS[pos];
         end
      endcase
      return label;
   endfunction

   // Advance the modifier state and queue the bytes one press sends
   function automatic void encode_press(input logic [5:0] pos, input logic app);
      logic [7:0]    label;
      logic [7:0]    ch;
      logic [7:0]    up;
      logic [7:0]    cur;
      logic [7:0]    seq [4];
      int            n;
      term_byte_type tb;
      label = label_at(layer_now, pos);
      if (label == K_NONE) return;
      if (label == K_CTRL) begin
         ctrl_armed = ~ctrl_armed;
         return;
      end
      if (label == K_SHIFT) begin
         layer_now = (layer_now == LAYER_SHIFT) ? LAYER_BASE : LAYER_SHIFT;
         return;
      end
      if (label == K_SYM) begin
         layer_now = (layer_now == LAYER_SYM) ? LAYER_BASE : LAYER_SYM;
         return;
      end

      cur = app ? CH_SS3 : CH_CSI;
      seq[0] = CH_ESC;
      seq[1] = 8'h00;
      seq[2] = 8'h00;
      seq[3] = 8'h00;
      if (label < 8'h80) begin
         // fold under Ctrl: lowercase raised first, space to NUL
         ch = label;
         if (ctrl_armed) begin
            up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
            if (ch == CH_SPACE) ch = 8'h00;
            else if (up >= 8'h40 && up <= 8'h5F) ch = up & CTRL_MASK;
         end
         seq[0] = ch;
         n = 1;
      end else begin
         case (label)
            K_ESC:   n = 1;
            K_TAB:   begin seq[0] = CH_TAB; n = 1; end
            K_BS:    begin seq[0] = CH_DEL; n = 1; end
            K_ENTER: begin seq[0] = CH_CR; n = 1; end
            K_UP:    begin seq[1] = cur; seq[2] = 8'h41; n = 3; end
            K_DOWN:  begin seq[1] = cur; seq[2] = 8'h42; n = 3; end
            K_RIGHT: begin seq[1] = cur; seq[2] = 8'h43; n = 3; end
            K_LEFT:  begin seq[1] = cur; seq[2] = 8'h44; n = 3; end
            K_HOME:  begin seq[1] = cur; seq[2] = 8'h48; n = 3; end
            K_END:   begin seq[1] = cur; seq[2] = 8'h46; n = 3; end
            K_PGUP:  begin seq[1] = CH_CSI; seq[2] = 8'h35; seq[3] = CH_TILDE; n = 4; end
            K_PGDN:  begin seq[1] = CH_CSI; seq[2] = 8'h36; seq[3] = CH_TILDE; n = 4; end
            K_INS:   begin seq[1] = CH_CSI; seq[2] = 8'h32; seq[3] = CH_TILDE; n = 4; end
            default: begin seq[1] = CH_CSI; seq[2] = 8'h33; seq[3] = CH_TILDE; n = 4; end
         endcase
      end

      for (int i = 0; i < n; i++) begin
         tb.code = seq[i];
         tb.last = (i == n - 1);
         term_bytes_q.push_back(tb);
      end
      // an emitting key drops the one-shot modifiers
      ctrl_armed = 1'b0;
      if (layer_now == LAYER_SHIFT) layer_now = LAYER_BASE;
   endfunction

   // Check each output transfer, then predict from each input transfer
   always @(posedge clock) begin : watch
      term_byte_type want;
      if (reset) begin
         layer_now = LAYER_BASE;
         ctrl_armed = 1'b0;
         term_bytes_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (term_bytes_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected byte %02h last %0b", $realtime, rsp_out_byte,
                           rsp_last_byte);
            end else begin
               want = term_bytes_q.pop_front();
               if (rsp_out_byte !== want.code || rsp_last_byte !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: byte exp %02h last %0b, got %02h last %0b", $realtime,
                              want.code, want.last, rsp_out_byte, rsp_last_byte);
               end
            end
         end
         if (req_valid && req_ready) encode_press(req_key_position, req_app_cursor_mode);
      end
      bytes_pending = term_bytes_q.size();
   end

endmodule

// ----- dv/tb_key_to_terminal_byte_encoder.sv -----
module tb_key_to_terminal_byte_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_KEYS  = 405;
   localparam int DRAIN_CYCLES = 20;

   // Modifier positions: base and shift layers, then symbol layer
   localparam logic [5:0] POS_CTRL      = 6'd23;
   localparam logic [5:0] POS_SHIFT     = 6'd34;
   localparam logic [5:0] POS_SYM       = 6'd45;
   localparam logic [5:0] POS_SYM_SHIFT = 6'd32;
   localparam logic [5:0] POS_SYM_SYM   = 6'd39;

   // Receiver stall modes
   localparam int READY_ALWAYS   = 0;
   localparam int READY_COIN     = 1;
   localparam int READY_PERIODIC = 2;
   localparam int READY_HOLD     = 3;

   // Directed presses as {app_cursor_mode, key_position}
   localparam logic [6:0] DIRECTED [0:24] = '{
      {1'b0, 6'd0},  {1'b1, 6'd13}, {1'b0, 6'd11}, {1'b0, 6'd12}, {1'b1, 6'd33},
      {1'b0, 6'd50}, {1'b1, 6'd52}, {1'b0, 6'd63}, {1'b0, POS_CTRL}, {1'b0, 6'd24},
      {1'b1, POS_CTRL}, {1'b0, 6'd48}, {1'b0, POS_SHIFT}, {1'b0, POS_CTRL}, {1'b1, 6'd46},
      {1'b0, POS_SYM}, {1'b1, 6'd33}, {1'b0, 6'd35}, {1'b1, 6'd38}, {1'b0, POS_CTRL},
      {1'b0, 6'd16}, {1'b1, 6'd47}, {1'b0, POS_SYM_SHIFT}, {1'b0, 6'd49}, {1'b1, 6'd53}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [5:0] req_key_position = 6'd0;
   logic       req_app_cursor_mode = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_byte;

   int fail_count;
   int bytes_pending;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = READY_ALWAYS;
   int mode_left = 0;
   int hold_left = 0;
   int ready_phase = 0;

   key_to_terminal_byte_encoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_position   (req_key_position),
      .req_app_cursor_mode(req_app_cursor_mode),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_byte      (rsp_last_byte)
   );

   key_to_terminal_byte_encoder_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_position   (req_key_position),
      .req_app_cursor_mode(req_app_cursor_mode),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_byte      (rsp_last_byte),
      .fail_count         (fail_count),
      .bytes_pending      (bytes_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: switch stall mode whenever the mode countdown runs out
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(READY_ALWAYS, READY_HOLD);
         mode_left = $urandom_range(20, 80);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: begin
            rsp_ready <= (ready_phase % 4) != 3;
            ready_phase++;
         end
         default: begin
            if (hold_left > 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(2, 10);
            end
         end
      endcase
   end

   // Present one press at a falling edge and hold it until the transfer
   task automatic drive_key(input logic [5:0] pos, input logic app);
      req_key_position = pos;
      req_app_cursor_mode = app;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Sender: bursts of back-to-back presses separated by gaps
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
      end
   endtask

   initial begin : stimulus
      logic [5:0] pos;
      int         pick;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         drive_key(DIRECTED[i][5:0], DIRECTED[i][6]);
         pace_sender();
      end

      // Mostly in-range presses, with modifiers hit often enough to walk the layers
      for (int i = 0; i < RANDOM_KEYS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            pos = 6'($urandom_range(0, 46));
         end else if (pick < 78) begin
            case ($urandom_range(0, 4))
               0: pos = POS_CTRL;
               1: pos = POS_SHIFT;
               2: pos = POS_SYM;
               3: pos = POS_SYM_SHIFT;
               default: pos = POS_SYM_SYM;
            endcase
         end else begin
            pos = 6'($urandom_range(0, 63));
         end
         drive_key(pos, 1'($urandom_range(0, 1)));
         pace_sender();
      end
      req_valid = 1'b0;

      // Drain and give the verdict
      wait (bytes_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
